// File: rtl/sbab_pkg.sv
package sbab_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int HANDLE_BITS_DEF = 16;

	localparam int BYTES_W  = 22;
	localparam int MSG_W    = 16;
	localparam int PORT_H_W = 16;
	localparam int CNT_W    = 7;
	localparam int BCNT_W   = 6;
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;

	localparam logic [BYTES_W-1:0] HARD_BYTES_RST  = 22'd1048576;
	localparam logic [CNT_W-1:0]   HARD_COUNT_RST  = 7'd64;
	localparam logic [BYTES_W-1:0] SOFT_BYTES_RST  = 22'd262144;
	localparam logic [CNT_W-1:0]   SOFT_COUNT_RST  = 7'd32;
	localparam logic [BYTES_W-1:0] BATCH_BYTES_RST = 22'd65536;
	localparam logic [BCNT_W-1:0]  BATCH_COUNT_RST = 6'd32;

	typedef enum logic [2:0] {
		KIND_ACCEPTED   = 3'd0,
		KIND_DROP_HARD  = 3'd1,
		KIND_DROP_SOFT  = 3'd2,
		KIND_DROP_OFF   = 3'd3,
		KIND_ENTRY      = 3'd4,
		KIND_IDLE       = 3'd5,
		KIND_PEER_CLOSE = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		REG_HARD_BYTES  = 3'd0,
		REG_HARD_COUNT  = 3'd1,
		REG_SOFT_BYTES  = 3'd2,
		REG_SOFT_COUNT  = 3'd3,
		REG_BATCH_BYTES = 3'd4,
		REG_BATCH_COUNT = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_RD,
		S_CUR,
		S_PEEK,
		S_EMIT
	} state_t;

	// result of the shared add-and-compare unit
	typedef struct packed {
		logic [BYTES_W:0] sum;
		logic             over;
	} addcmp_t;

endpackage

// File: rtl/sbab_ram.sv
module sbab_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/sbab_addcmp.sv
module sbab_addcmp (
	input  logic [sbab_pkg::BYTES_W-1:0] a,
	input  logic [sbab_pkg::BYTES_W-1:0] b,
	input  logic [sbab_pkg::BYTES_W-1:0] lim,
	output sbab_pkg::addcmp_t            res
);

	import sbab_pkg::*;

	logic [BYTES_W:0] sum;

	always_comb begin
		sum      = {1'b0, a} + {1'b0, b};
		res.sum  = sum;
		res.over = (sum > {1'b0, lim});
	end

endmodule

// File: rtl/send_backlog_admission_batcher_top.sv
// Channel | Direction | Handshake         | Payload
// in      | to block  | in_valid/in_stall | mode msg_handle msg_bytes done_bytes link_up
// out     | from block| out_valid/out_stall| kind entry_handle entry_bytes last
//         |           |                   |   backlog_count_out backlog_bytes_out
// cfg     | to block  | APB psel/penable  | paddr pwdata prdata pready
//
// An item is taken in one cycle and evaluated in the next. Batch forming runs on one read
// port of the descriptor RAM: the first entry passes through read of the head, dequeue,
// peek at the next size through the shared add-compare unit, and emit; each further
// entry passes through dequeue, peek and emit; the peek is skipped when the queue or
// the batch count ends the batch.
// in_stall is high from acceptance until the last result is in the output
// register; a stalled output register holds the sequencer. Reset clears all
// control state; the descriptor RAM needs no clearing.
module send_backlog_admission_batcher_top #(
	parameter int QUEUE_DEPTH = sbab_pkg::QUEUE_DEPTH_DEF,
	parameter int HANDLE_BITS = sbab_pkg::HANDLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          mode,
	input  logic [sbab_pkg::PORT_H_W-1:0] msg_handle,
	input  logic [sbab_pkg::MSG_W-1:0]    msg_bytes,
	input  logic [sbab_pkg::BYTES_W-1:0]  done_bytes,
	input  logic                          link_up,

	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    kind,
	output logic [sbab_pkg::PORT_H_W-1:0] entry_handle,
	output logic [sbab_pkg::MSG_W-1:0]    entry_bytes,
	output logic                          last,
	output logic [sbab_pkg::CNT_W-1:0]    backlog_count_out,
	output logic [sbab_pkg::BYTES_W-1:0]  backlog_bytes_out,

	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sbab_pkg::PADDR_W-1:0]  paddr,
	input  logic [sbab_pkg::PDATA_W-1:0]  pwdata,
	output logic [sbab_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	import sbab_pkg::*;

	localparam int AW   = $clog2(QUEUE_DEPTH);
	localparam int CW   = $clog2(QUEUE_DEPTH + 1);
	localparam int CMPW = (CW > CNT_W) ? CW : CNT_W;
	localparam int DW   = HANDLE_BITS + MSG_W;

	// configuration
	logic [BYTES_W-1:0] hard_bytes_q, soft_bytes_q, batch_bytes_q;
	logic [CNT_W-1:0]   hard_count_q, soft_count_q;
	logic [BCNT_W-1:0]  batch_count_q;
	reg_idx_t           reg_idx;

	// captured item
	logic               mode_q, link_q, done_nz_q;
	logic [PORT_H_W-1:0] handle_q;
	logic [MSG_W-1:0]   msg_bytes_q;

	// queue state
	state_t             state_q, state_nx;
	logic [AW-1:0]      head_q, tail_q, head_inc, tail_inc;
	logic [CW-1:0]      count_q;
	logic [BYTES_W-1:0] bytes_q;
	logic               in_flight_q;

	// batch state
	logic [BYTES_W-1:0]     batched_q;
	logic [BCNT_W-1:0]      taken_q;
	logic [HANDLE_BITS-1:0] cur_handle_q;
	logic [MSG_W-1:0]       cur_bytes_q;
	logic                   more_q;

	// output register
	logic               out_valid_q, last_q;
	kind_t              kind_q;
	logic [PORT_H_W-1:0] entry_handle_q;
	logic [MSG_W-1:0]   entry_bytes_q;
	logic [CNT_W-1:0]   count_out_q;
	logic [BYTES_W-1:0] bytes_out_q;

	// RAM
	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [DW-1:0]      ram_wdata, ram_rdata;
	logic [MSG_W-1:0]   rd_bytes;
	logic [HANDLE_BITS-1:0] rd_handle;

	// shared unit
	logic [BYTES_W-1:0] ac_a, ac_b, ac_lim;
	addcmp_t            ac_res;

	// control
	logic               slot_free, in_accept, cfg_write, out_load;
	logic [CMPW-1:0]    count_ext;
	logic               hard_drop, soft_drop;
	logic               ev_emit, ev_enq, ev_batch, ev_clr_flight, ev_last, ev_go;
	kind_t              ev_kind;
	logic               peek_ok;
	logic [CW-1:0]      count_dec;
	logic [31:0]        handle_wide, cur_handle_wide;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign cfg_write = psel && penable && pwrite;
	assign pready    = 1'b1;
	assign reg_idx   = reg_idx_t'(paddr[4:2]);

	assign head_inc  = (32'(head_q) + 32'd1 == 32'(QUEUE_DEPTH)) ? '0 : head_q + 1'b1;
	assign tail_inc  = (32'(tail_q) + 32'd1 == 32'(QUEUE_DEPTH)) ? '0 : tail_q + 1'b1;
	assign count_ext = CMPW'(count_q);
	assign count_dec = count_q - 1'b1;

	assign handle_wide     = 32'(handle_q);
	assign cur_handle_wide = 32'(cur_handle_q);
	assign ram_wdata       = {handle_wide[HANDLE_BITS-1:0], msg_bytes_q};
	assign rd_bytes        = ram_rdata[MSG_W-1:0];
	assign rd_handle       = ram_rdata[DW-1:MSG_W];

	always_comb begin
		if (state_q == S_EVAL) begin
			ac_a   = bytes_q;
			ac_b   = BYTES_W'(msg_bytes_q);
			ac_lim = hard_bytes_q;
		end else begin
			ac_a   = batched_q;
			ac_b   = BYTES_W'(rd_bytes);
			ac_lim = batch_bytes_q;
		end
	end

	sbab_addcmp u_addcmp (
		.a   (ac_a),
		.b   (ac_b),
		.lim (ac_lim),
		.res (ac_res)
	);

	sbab_ram #(
		.WIDTH (DW),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// admission and completion decision
	always_comb begin
		hard_drop = (count_q >= CW'(QUEUE_DEPTH)) || ac_res.over ||
			(count_ext >= CMPW'(hard_count_q));
		soft_drop = in_flight_q && ((bytes_q >= soft_bytes_q) ||
			(count_ext >= CMPW'(soft_count_q)));
		ev_emit       = 1'b1;
		ev_enq        = 1'b0;
		ev_batch      = 1'b0;
		ev_clr_flight = 1'b0;
		ev_last       = 1'b1;
		ev_kind       = KIND_ACCEPTED;
		if (!mode_q) begin
			if (!link_q) begin
				ev_kind = KIND_DROP_OFF;
			end else if (hard_drop) begin
				ev_kind = KIND_DROP_HARD;
			end else if (soft_drop) begin
				ev_kind = KIND_DROP_SOFT;
			end else begin
				ev_enq   = 1'b1;
				ev_last  = in_flight_q;
				ev_batch = !in_flight_q;
			end
		end else begin
			if (!done_nz_q) begin
				ev_kind = KIND_PEER_CLOSE;
			end else if (count_q == '0) begin
				ev_kind       = KIND_IDLE;
				ev_clr_flight = 1'b1;
			end else if (!link_q) begin
				ev_kind = KIND_DROP_OFF;
			end else begin
				ev_emit  = 1'b0;
				ev_batch = 1'b1;
			end
		end
		ev_go = !ev_emit || slot_free;
	end

	assign peek_ok = (count_dec != '0) && ((taken_q + 1'b1) < batch_count_q);

	assign out_load = (state_q == S_EVAL && ev_go && ev_emit) ||
		(state_q == S_EMIT && slot_free);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					state_nx = S_EVAL;
				end
			end
			S_EVAL: begin
				if (ev_go) begin
					state_nx = ev_batch ? S_RD : S_IDLE;
				end
			end
			S_RD:   state_nx = S_CUR;
			S_CUR:  state_nx = peek_ok ? S_PEEK : S_EMIT;
			S_PEEK: state_nx = S_EMIT;
			S_EMIT: begin
				if (slot_free) begin
					state_nx = more_q ? S_CUR : S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = head_q;
		unique case (state_q)
			S_EVAL: ram_we = ev_go && ev_enq;
			S_RD:   ram_re = 1'b1;
			S_CUR: begin
				ram_re    = peek_ok;
				ram_raddr = head_inc;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			bytes_q     <= '0;
			in_flight_q <= 1'b0;
			out_valid_q <= 1'b0;
			more_q      <= 1'b0;
			batched_q   <= '0;
			taken_q     <= '0;
		end else begin
			state_q <= state_nx;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_EVAL: begin
					if (ev_go) begin
						if (ev_enq) begin
							tail_q  <= tail_inc;
							count_q <= count_q + 1'b1;
							bytes_q <= ac_res.sum[BYTES_W-1:0];
						end
						if (ev_batch) begin
							batched_q <= '0;
							taken_q   <= '0;
						end
						if (ev_clr_flight) begin
							in_flight_q <= 1'b0;
						end
					end
				end
				S_CUR: begin
					head_q    <= head_inc;
					count_q   <= count_dec;
					bytes_q   <= bytes_q - BYTES_W'(rd_bytes);
					batched_q <= batched_q + BYTES_W'(rd_bytes);
					taken_q   <= taken_q + 1'b1;
					if (!peek_ok) begin
						more_q <= 1'b0;
					end
				end
				S_PEEK: more_q <= !ac_res.over;
				S_EMIT: begin
					if (slot_free && !more_q) begin
						in_flight_q <= 1'b1;
					end
				end
				default: begin
					more_q <= more_q;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			mode_q      <= mode;
			handle_q    <= msg_handle;
			msg_bytes_q <= msg_bytes;
			done_nz_q   <= (done_bytes != '0);
			link_q      <= link_up;
		end
		if (state_q == S_CUR) begin
			cur_handle_q <= rd_handle;
			cur_bytes_q  <= rd_bytes;
		end
		if (state_q == S_EVAL && ev_go && ev_emit) begin
			kind_q         <= ev_kind;
			entry_handle_q <= '0;
			entry_bytes_q  <= '0;
			last_q         <= ev_last;
			if (ev_enq) begin
				count_out_q <= CNT_W'(count_q + 1'b1);
				bytes_out_q <= ac_res.sum[BYTES_W-1:0];
			end else begin
				count_out_q <= count_ext[CNT_W-1:0];
				bytes_out_q <= bytes_q;
			end
		end else if (state_q == S_EMIT && slot_free) begin
			kind_q         <= KIND_ENTRY;
			entry_handle_q <= cur_handle_wide[PORT_H_W-1:0];
			entry_bytes_q  <= cur_bytes_q;
			last_q         <= !more_q;
			count_out_q    <= count_ext[CNT_W-1:0];
			bytes_out_q    <= bytes_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign kind              = kind_q;
	assign entry_handle      = entry_handle_q;
	assign entry_bytes       = entry_bytes_q;
	assign last              = last_q;
	assign backlog_count_out = count_out_q;
	assign backlog_bytes_out = bytes_out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hard_bytes_q  <= HARD_BYTES_RST;
			hard_count_q  <= HARD_COUNT_RST;
			soft_bytes_q  <= SOFT_BYTES_RST;
			soft_count_q  <= SOFT_COUNT_RST;
			batch_bytes_q <= BATCH_BYTES_RST;
			batch_count_q <= BATCH_COUNT_RST;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_HARD_BYTES:  hard_bytes_q  <= pwdata[BYTES_W-1:0];
				REG_HARD_COUNT:  hard_count_q  <= pwdata[CNT_W-1:0];
				REG_SOFT_BYTES:  soft_bytes_q  <= pwdata[BYTES_W-1:0];
				REG_SOFT_COUNT:  soft_count_q  <= pwdata[CNT_W-1:0];
				REG_BATCH_BYTES: batch_bytes_q <= pwdata[BYTES_W-1:0];
				REG_BATCH_COUNT: batch_count_q <= pwdata[BCNT_W-1:0];
				default: begin
					hard_bytes_q <= hard_bytes_q;
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_HARD_BYTES:  prdata = PDATA_W'(hard_bytes_q);
			REG_HARD_COUNT:  prdata = PDATA_W'(hard_count_q);
			REG_SOFT_BYTES:  prdata = PDATA_W'(soft_bytes_q);
			REG_SOFT_COUNT:  prdata = PDATA_W'(soft_count_q);
			REG_BATCH_BYTES: prdata = PDATA_W'(batch_bytes_q);
			REG_BATCH_COUNT: prdata = PDATA_W'(batch_count_q);
			default:         prdata = '0;
		endcase
	end

endmodule

// File: tb/tb.sv
module tb;
	import sbab_pkg::*;

	localparam int DEPTH       = QUEUE_DEPTH_DEF;
	localparam int QAW         = $clog2(DEPTH);
	localparam int CYCLE_LIMIT = 400000;
	localparam int BYTES_MAX   = (1 << BYTES_W) - 1;
	localparam int DONE_MAX    = 4194240;

	typedef struct {
		logic                mode;
		logic [PORT_H_W-1:0] handle;
		logic [MSG_W-1:0]    size;
		logic [BYTES_W-1:0]  done;
		logic                link;
	} tx_item_t;

	typedef struct {
		kind_t               kind;
		logic [PORT_H_W-1:0] handle;
		logic [MSG_W-1:0]    size;
		logic                last;
		logic [CNT_W-1:0]    count;
		logic [BYTES_W-1:0]  bytes;
	} tx_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 mode = 1'b0;
	logic [PORT_H_W-1:0]  msg_handle = '0;
	logic [MSG_W-1:0]     msg_bytes = '0;
	logic [BYTES_W-1:0]   done_bytes = '0;
	logic                 link_up = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [2:0]           kind;
	logic [PORT_H_W-1:0]  entry_handle;
	logic [MSG_W-1:0]     entry_bytes;
	logic                 last;
	logic [CNT_W-1:0]     backlog_count_out;
	logic [BYTES_W-1:0]   backlog_bytes_out;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [PADDR_W-1:0]   paddr = '0;
	logic [PDATA_W-1:0]   pwdata = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	send_backlog_admission_batcher_top u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.mode              (mode),
		.msg_handle        (msg_handle),
		.msg_bytes         (msg_bytes),
		.done_bytes        (done_bytes),
		.link_up           (link_up),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.kind              (kind),
		.entry_handle      (entry_handle),
		.entry_bytes       (entry_bytes),
		.last              (last),
		.backlog_count_out (backlog_count_out),
		.backlog_bytes_out (backlog_bytes_out),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the block: register copies and descriptor queue
	int unsigned         cap [6] = '{32'(HARD_BYTES_RST), 32'(HARD_COUNT_RST),
		32'(SOFT_BYTES_RST), 32'(SOFT_COUNT_RST), 32'(BATCH_BYTES_RST),
		32'(BATCH_COUNT_RST)};
	logic [PORT_H_W-1:0] q_handle [DEPTH];
	logic [MSG_W-1:0]    q_size [DEPTH];
	logic [QAW-1:0]      q_head = '0;
	logic [QAW-1:0]      q_tail = '0;
	int unsigned         q_count = 0;
	int unsigned         q_bytes = 0;
	bit                  q_busy = 1'b0;

	tx_item_t   pend_q [$];
	tx_result_t due_results [$];
	tx_item_t   cur;
	int         burst_left = 1;
	int         gap_left = 0;
	int         stall_cyc = 0;
	int         stall_mode = 0;
	int         fails = 0;
	int         cycles = 0;

	task automatic add_item(tx_item_t it);
		pend_q.insert(pend_q.size(), it);
	endtask

	task automatic push_result(kind_t k, logic [PORT_H_W-1:0] h, logic [MSG_W-1:0] b,
		logic l);
		tx_result_t r;
		r.kind   = k;
		r.handle = h;
		r.size   = b;
		r.last   = l;
		r.count  = q_count[CNT_W-1:0];
		r.bytes  = q_bytes[BYTES_W-1:0];
		due_results.insert(due_results.size(), r);
	endtask

	// dequeue one batch: the head always goes, later entries within the batch caps
	task automatic dispatch_batch();
		int unsigned         taken;
		int unsigned         batched;
		int unsigned         sz;
		logic [PORT_H_W-1:0] h;
		bit                  more;
		taken   = 0;
		batched = 0;
		do begin
			sz = 32'(q_size[q_head]);
			h  = q_handle[q_head];
			q_head = QAW'((32'(q_head) + 1) % DEPTH);
			q_count--;
			q_bytes -= sz;
			batched += sz;
			taken++;
			more = q_count > 0 && taken < cap[REG_BATCH_COUNT] &&
				batched + 32'(q_size[q_head]) <= cap[REG_BATCH_BYTES];
			push_result(KIND_ENTRY, h, sz[MSG_W-1:0], !more);
		end while (more);
		q_busy = 1'b1;
	endtask

	task automatic admit_and_batch(tx_item_t it);
		if (it.mode == 1'b0) begin
			if (!it.link) begin
				push_result(KIND_DROP_OFF, '0, '0, 1'b1);
			end else if (q_count >= DEPTH || q_bytes + 32'(it.size) > cap[REG_HARD_BYTES] ||
				q_count + 1 > cap[REG_HARD_COUNT]) begin
				push_result(KIND_DROP_HARD, '0, '0, 1'b1);
			end else if (q_busy && (q_bytes >= cap[REG_SOFT_BYTES] ||
				q_count >= cap[REG_SOFT_COUNT])) begin
				push_result(KIND_DROP_SOFT, '0, '0, 1'b1);
			end else begin
				q_handle[q_tail] = it.handle;
				q_size[q_tail]   = it.size;
				q_tail = QAW'((32'(q_tail) + 1) % DEPTH);
				q_count++;
				q_bytes += 32'(it.size);
				push_result(KIND_ACCEPTED, '0, '0, q_busy);
				if (!q_busy)
					dispatch_batch();
			end
		end else if (it.done == '0) begin
			push_result(KIND_PEER_CLOSE, '0, '0, 1'b1);
		end else if (q_count == 0) begin
			q_busy = 1'b0;
			push_result(KIND_IDLE, '0, '0, 1'b1);
		end else if (!it.link) begin
			push_result(KIND_DROP_OFF, '0, '0, 1'b1);
		end else begin
			dispatch_batch();
		end
	endtask

	function automatic void chk_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endfunction

	// sender: bursts of beats with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				admit_and_batch(cur);
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pend_q.size() > 0) begin
					cur = pend_q.pop_front();
					mode       <= cur.mode;
					msg_handle <= cur.handle;
					msg_bytes  <= cur.size;
					done_bytes <= cur.done;
					link_up    <= cur.link;
					in_valid   <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each result taken and draws its stall pattern from four kinds
	always @(posedge clk or negedge arst_n) begin
		tx_result_t r;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					$error("result with no expectation waiting: kind %0d", kind);
					fails++;
				end else begin
					r = due_results.pop_front();
					chk_field("kind", 32'(r.kind), 32'(kind));
					chk_field("entry_handle", 32'(r.handle), 32'(entry_handle));
					chk_field("entry_bytes", 32'(r.size), 32'(entry_bytes));
					chk_field("last", 32'(r.last), 32'(last));
					chk_field("backlog_count_out", 32'(r.count), 32'(backlog_count_out));
					chk_field("backlog_bytes_out", 32'(r.bytes), 32'(backlog_bytes_out));
				end
			end
			stall_cyc++;
			if (stall_cyc >= 150) begin
				stall_cyc = 0;
				stall_mode = $urandom_range(0, 3);
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= (stall_cyc % 7) < 3;
			endcase
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic tx_item_t mk(logic m, int unsigned h, int unsigned b, int unsigned d,
		logic l);
		tx_item_t it;
		it.mode   = m;
		it.handle = h[PORT_H_W-1:0];
		it.size   = b[MSG_W-1:0];
		it.done   = d[BYTES_W-1:0];
		it.link   = l;
		return it;
	endfunction

	function automatic tx_item_t enq_item(logic l);
		int unsigned b;
		b = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 65535);
		return mk(1'b0, $urandom, b, $urandom_range(0, DONE_MAX), l);
	endfunction

	function automatic tx_item_t done_item(logic l);
		return mk(1'b1, $urandom, $urandom, $urandom_range(1, DONE_MAX), l);
	endfunction

	function automatic int unsigned pick4(int unsigned a, int unsigned b, int unsigned c,
		int unsigned d);
		case ($urandom_range(0, 3))
			0: return a;
			1: return b;
			2: return c;
			default: return d;
		endcase
	endfunction

	task automatic reg_write(reg_idx_t r, int unsigned v);
		int unsigned w;
		case (r) inside
			REG_HARD_COUNT, REG_SOFT_COUNT: w = CNT_W;
			REG_BATCH_COUNT: w = BCNT_W;
			default: w = BYTES_W;
		endcase
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cap[r] = v & ((1 << w) - 1);
	endtask

	// hold off until every beat is in and every result is out
	task automatic wait_drained();
		do @(negedge clk); while (pend_q.size() != 0 || in_valid || due_results.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	// mostly enqueue runs closed by completions, the rest noise
	task automatic queue_traffic(int n);
		int added;
		int k;
		tx_item_t it;
		added = 0;
		while (added < n) begin
			if ($urandom_range(0, 9) < 7) begin
				k = $urandom_range(1, 12);
				repeat (k) add_item(enq_item($urandom_range(0, 19) != 0));
				added += k;
				k = $urandom_range(1, 3);
				repeat (k) add_item(done_item($urandom_range(0, 19) != 0));
				added += k;
			end else begin
				it = mk(1'($urandom_range(0, 1)), $urandom, $urandom,
					($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, DONE_MAX),
					1'($urandom_range(0, 1)));
				add_item(it);
				added++;
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// link down, idle completion, closed peer, accept while idle and in flight
		add_item(mk(1'b0, 'hFFFF, 'hFFFF, DONE_MAX, 1'b0));
		add_item(mk(1'b1, 'h0001, 'h0002, 5, 1'b1));
		add_item(mk(1'b1, 'h0003, 'h0004, 0, 1'b1));
		add_item(mk(1'b0, 'h0000, 'h0000, 0, 1'b1));
		add_item(mk(1'b0, 'hFFFF, 'hFFFF, 0, 1'b1));
		add_item(mk(1'b0, 'h1234, 'h0001, 0, 1'b1));
		add_item(mk(1'b0, 'h8000, 'h8000, 0, 1'b1));
		add_item(mk(1'b1, 'h5555, 'hAAAA, 0, 1'b1));
		add_item(mk(1'b1, 'hAAAA, 'h5555, DONE_MAX, 1'b0));
		add_item(mk(1'b1, 'h0000, 'h0000, DONE_MAX, 1'b1));
		add_item(mk(1'b1, 'h0000, 'h0000, 1, 1'b1));
		add_item(mk(1'b1, 'h0000, 'h0000, 'h3FFFFF, 1'b1));
		wait_drained();

		reg_write(REG_HARD_COUNT, 0);
		add_item(mk(1'b0, 'h00F0, 'h0010, 0, 1'b1));
		wait_drained();

		reg_write(REG_HARD_COUNT, 64);
		reg_write(REG_HARD_BYTES, 100);
		add_item(mk(1'b0, 'h0101, 101, 0, 1'b1));
		add_item(mk(1'b0, 'h0100, 100, 0, 1'b1));
		wait_drained();

		reg_write(REG_SOFT_BYTES, 0);
		add_item(mk(1'b0, 'h0005, 5, 0, 1'b1));
		wait_drained();

		reg_write(REG_SOFT_BYTES, BYTES_MAX);
		reg_write(REG_SOFT_COUNT, 0);
		add_item(mk(1'b0, 'h0006, 6, 0, 1'b1));
		wait_drained();

		// single-entry batches
		reg_write(REG_SOFT_COUNT, 64);
		reg_write(REG_BATCH_COUNT, 0);
		reg_write(REG_BATCH_BYTES, BYTES_MAX);
		reg_write(REG_HARD_BYTES, BYTES_MAX);
		add_item(mk(1'b0, 'h000A, 10, 0, 1'b1));
		add_item(mk(1'b0, 'h0014, 20, 0, 1'b1));
		add_item(mk(1'b1, 'h0000, 'h0000, 7, 1'b1));
		add_item(mk(1'b1, 'h0000, 'h0000, 7, 1'b1));
		add_item(mk(1'b1, 'h0000, 'h0000, 7, 1'b1));
		wait_drained();

		// fill the queue past its depth, then drain it in maximal batches
		reg_write(REG_HARD_COUNT, 127);
		reg_write(REG_SOFT_COUNT, 127);
		reg_write(REG_BATCH_COUNT, 63);
		add_item(enq_item(1'b1));
		repeat (70) add_item(enq_item(1'b1));
		repeat (3) add_item(done_item(1'b1));
		wait_drained();

		repeat (5) begin
			reg_write(REG_HARD_BYTES, pick4(BYTES_MAX, $urandom_range(65536, 1048576),
				$urandom_range(0, 200000), 32'(HARD_BYTES_RST)));
			reg_write(REG_HARD_COUNT, pick4(64, 127, $urandom_range(1, 64), $urandom_range(1, 8)));
			reg_write(REG_SOFT_BYTES, pick4(BYTES_MAX, $urandom_range(0, 300000),
				$urandom_range(0, 40000), 32'(SOFT_BYTES_RST)));
			reg_write(REG_SOFT_COUNT, pick4(64, $urandom_range(0, 64), $urandom_range(1, 6),
				32'(SOFT_COUNT_RST)));
			reg_write(REG_BATCH_BYTES, pick4(0, $urandom_range(0, 20000), BYTES_MAX,
				32'(BATCH_BYTES_RST)));
			reg_write(REG_BATCH_COUNT, pick4(1, 63, $urandom_range(0, 63), $urandom_range(1, 8)));
			queue_traffic(72);
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (fails == 0 && due_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
